/* src/cycle_timer_bank_assert.svh */
// assertion macros for the cycle timer bank rtl
// no dependencies; included inside module bodies
`ifndef CYCLE_TIMER_BANK_ASSERT_SVH
`define CYCLE_TIMER_BANK_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ctb_pkg.sv */
// types and constants of the cycle timer bank
// no dependencies; imported by ctb_ram users and the top level
package ctb_pkg;

    // bank size defaults
    localparam int NUM_TIMERS_DEF = 8;
    localparam int NUM_CPUS_DEF   = 4;

    // configuration port
    localparam int          CFG_NUM     = 4;
    localparam int          CFG_IDX_W   = 3;
    localparam logic [31:0] FRAME_RESET = 32'd25000;

    // action codes
    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_ADVANCE  = 3'd1;
    localparam logic [2:0] ACT_FREE     = 3'd2;
    localparam logic [2:0] ACT_ZERO_CPU = 3'd3;
    localparam logic [2:0] ACT_ZERO_ONE = 3'd4;
    localparam logic [2:0] ACT_ZERO_ALL = 3'd5;

    // result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    // input beat
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] period_cycles;
        logic [1:0]  cpu_select;
        logic        auto_free;
        logic [15:0] handler_data;
        logic [15:0] cycles;
        logic [2:0]  timer_index;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic        result_kind;
        logic [2:0]  timer_id;
        logic [15:0] fired_data;
        logic        last_result;
    } t_out_item;

    // static part of one timer entry
    typedef struct packed {
        logic [1:0]  cpu;
        logic        auto_free;
        logic [31:0] period;
        logic [15:0] data;
    } t_timer_cfg;

endpackage

/* src/ctb_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ctb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/cycle_timer_bank.sv */
// cycle timer bank top level: command fsm, sweep engine and output stage
// depends on ctb_pkg, ctb_ram and cycle_timer_bank_assert.svh
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in_item) takes one command beat
//   at a time; o_in_ready is high only while no command is in progress.
//   output channel (o_out_valid / i_out_ready / o_out_item) is one output
//   register; the last beat caused by a command has last_result set.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready and writes frame cycle limits, index 0..3; others ignored.
// command handling
//   free and zero one complete in the accept cycle. allocate: the reply is
//   loaded from S_ALLOC once the output register is free. advance, zero cpu
//   counts, zero all: the sweep reads one timer entry per cycle from the entry
//   rams unless stalled, modifies it and writes the count back.
// reset
//   all timers free, frame limits 25000, no output pending; the rams are not
//   cleared at reset.
// stall
//   a stalled receiver holds the sweep on the current timer until the fired
//   beat ahead of it leaves the output register.
module cycle_timer_bank #(
    parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF,
    parameter int NUM_CPUS   = ctb_pkg::NUM_CPUS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ctb_pkg::t_in_item                    i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ctb_pkg::t_out_item                   o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);
    import ctb_pkg::*;
    `include "cycle_timer_bank_assert.svh"

    localparam int TW = $clog2(NUM_TIMERS);
    localparam int IW = (TW > 3) ? TW : 3;
    localparam int CW = $bits(t_timer_cfg);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_SWEEP,
        S_FLUSH
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_cmd, n_cmd;
    logic [TW-1:0]      r_cur, n_cur;
    logic               r_pend_valid, n_pend_valid;
    logic [2:0]         r_pend_num, n_pend_num;
    logic [15:0]        r_pend_data, n_pend_data;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic [NUM_TIMERS-1:0] r_enabled, n_enabled;
    logic [31:0]        r_frame [CFG_NUM];

    // ram ports
    logic               cfg_we;
    logic [TW-1:0]      cfg_waddr;
    t_timer_cfg         cfg_wdata;
    logic [CW-1:0]      cfg_rdata;
    t_timer_cfg         cfg_rd;
    logic               cnt_we;
    logic [TW-1:0]      cnt_waddr;
    logic [31:0]        cnt_wdata;
    logic [31:0]        cnt_rd;
    logic [TW-1:0]      raddr;

    // helpers
    logic               in_acc;
    logic               out_free;
    logic               in_idx_ok;
    logic [IW-1:0]      in_idx_ext;
    logic [TW-1:0]      in_idx;
    logic               in_cpu_ok;
    logic               cmd_cpu_ok;
    logic               got;
    logic [TW-1:0]      got_idx;
    logic [IW-1:0]      got_ext;
    logic [IW-1:0]      cur_ext;
    logic               cur_last;
    logic               cur_match;
    logic [32:0]        sum;
    logic [31:0]        sat_cnt;
    logic               fire;
    logic               sweep_stall;
    logic [31:0]        alloc_period;

    assign cfg_rd = t_timer_cfg'(cfg_rdata);

    ctb_ram #(.WIDTH(CW), .DEPTH(NUM_TIMERS)) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (cfg_we),
        .i_waddr (cfg_waddr),
        .i_wdata (CW'(cfg_wdata)),
        .i_raddr (raddr),
        .o_rdata (cfg_rdata)
    );

    ctb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (raddr),
        .o_rdata (cnt_rd)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // index and cpu range checks
    assign in_idx_ext = IW'(i_in_item.timer_index);
    assign in_idx     = in_idx_ext[TW-1:0];
    assign in_idx_ok  = int'(i_in_item.timer_index) < NUM_TIMERS;
    assign in_cpu_ok  = int'(i_in_item.cpu_select) < NUM_CPUS;
    assign cmd_cpu_ok = int'(r_cmd.cpu_select) < NUM_CPUS;

    // lowest free timer from index 1
    always_comb begin
        got     = 1'b0;
        got_idx = '0;
        for (int t = NUM_TIMERS - 1; t >= 1; t--) begin
            if (!r_enabled[t]) begin
                got     = 1'b1;
                got_idx = TW'(t);
            end
        end
    end
    assign got_ext = IW'(got_idx);

    // one-shot period clamp
    assign alloc_period = (r_cmd.auto_free && r_cmd.period_cycles > r_frame[r_cmd.cpu_select])
                          ? r_frame[r_cmd.cpu_select] : r_cmd.period_cycles;

    // saturating count update and fire test for the entry on the read port
    assign cur_ext   = IW'(r_cur);
    assign cur_last  = (r_cur == TW'(NUM_TIMERS - 1));
    assign cur_match = r_enabled[r_cur] && (cfg_rd.cpu == r_cmd.cpu_select);
    assign sum       = {1'b0, cnt_rd} + 33'(r_cmd.cycles);
    assign sat_cnt   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign fire      = (r_cmd.action == ACT_ADVANCE) && cur_match && (sat_cnt >= cfg_rd.period);
    assign sweep_stall = (r_state == S_SWEEP) && fire && r_pend_valid && !out_free;

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_cur        = r_cur;
        n_pend_valid = r_pend_valid;
        n_pend_num   = r_pend_num;
        n_pend_data  = r_pend_data;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_enabled    = r_enabled;
        cfg_we       = 1'b0;
        cfg_waddr    = got_idx;
        cfg_wdata    = '{cpu: r_cmd.cpu_select, auto_free: r_cmd.auto_free,
                         period: alloc_period, data: r_cmd.handler_data};
        cnt_we       = 1'b0;
        cnt_waddr    = r_cur;
        cnt_wdata    = '0;
        raddr        = r_cur;

        // output register drains
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = i_in_item;
                    n_cur = '0;
                    raddr = '0;
                    case (i_in_item.action)
                        ACT_ALLOC: begin
                            n_state = S_ALLOC;
                        end
                        ACT_ADVANCE, ACT_ZERO_CPU: begin
                            if (in_cpu_ok) begin
                                n_state = S_SWEEP;
                            end
                        end
                        ACT_ZERO_ALL: begin
                            n_state = S_SWEEP;
                        end
                        ACT_FREE: begin
                            if (in_idx_ok) begin
                                n_enabled[in_idx] = 1'b0;
                            end
                        end
                        ACT_ZERO_ONE: begin
                            if (in_idx_ok && r_enabled[in_idx]) begin
                                cnt_we    = 1'b1;
                                cnt_waddr = in_idx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // claim a free entry when one exists and the cpu is valid, and reply
            S_ALLOC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: KIND_REPLY, timer_id: 3'd0,
                                    fired_data: 16'd0, last_result: 1'b1};
                    if (got && cmd_cpu_ok) begin
                        n_out.timer_id     = got_ext[2:0];
                        cfg_we             = 1'b1;
                        cnt_we             = 1'b1;
                        cnt_waddr          = got_idx;
                        n_enabled[got_idx] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end

            // one entry per cycle unless stalled, next entry read ahead
            S_SWEEP: begin
                if (!sweep_stall) begin
                    raddr = cur_last ? r_cur : r_cur + TW'(1);
                    case (r_cmd.action)
                        ACT_ADVANCE: begin
                            if (cur_match) begin
                                cnt_we    = 1'b1;
                                cnt_wdata = fire ? 32'd0 : sat_cnt;
                            end
                            if (fire) begin
                                if (r_pend_valid) begin
                                    n_out_valid = 1'b1;
                                    n_out       = '{result_kind: KIND_FIRED,
                                                    timer_id: r_pend_num,
                                                    fired_data: r_pend_data,
                                                    last_result: 1'b0};
                                end
                                n_pend_valid = 1'b1;
                                n_pend_num   = cur_ext[2:0];
                                n_pend_data  = cfg_rd.data;
                                if (cfg_rd.auto_free) begin
                                    n_enabled[r_cur] = 1'b0;
                                end
                            end
                        end
                        ACT_ZERO_CPU: begin
                            if (r_cur != '0 && cfg_rd.cpu == r_cmd.cpu_select) begin
                                cnt_we = 1'b1;
                            end
                        end
                        ACT_ZERO_ALL: begin
                            if (r_enabled[r_cur]) begin
                                cnt_we = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (cur_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_cur = r_cur + TW'(1);
                    end
                end
            end

            // last fired beat of an advance, if any
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = '{result_kind: KIND_FIRED, timer_id: r_pend_num,
                                     fired_data: r_pend_data, last_result: 1'b1};
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_enabled    <= '0;
            r_cur        <= '0;
            for (int c = 0; c < CFG_NUM; c++) begin
                r_frame[c] <= FRAME_RESET;
            end
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_enabled    <= n_enabled;
            r_cur        <= n_cur;
            if (i_cfg_valid && int'(i_cfg_index) < CFG_NUM) begin
                r_frame[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
        r_cmd       <= n_cmd;
        r_pend_num  <= n_pend_num;
        r_pend_data <= n_pend_data;
        r_out       <= n_out;
    end

    // checks
    `CTB_ASSERT_IMP(a_timer0_free, i_clk, i_rst_n, 1'b1, !r_enabled[0], "timer 0 was claimed")
    `CTB_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_valid, "fired beat left pending")
    `CTB_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, sweep_stall, $stable(r_cur) && r_state == S_SWEEP, "sweep moved while stalled")
    `CTB_ASSERT_NXT(a_alloc_reply, i_clk, i_rst_n, r_state == S_ALLOC && out_free, r_out_valid && r_out.result_kind == KIND_REPLY && r_out.last_result, "allocate reply missing")

endmodule
